### rtl/core/asc_pkg.sv
package asc_pkg;

    // width of the internal byte position counter
    localparam int OFFSET_BITS = 24;
    // width of the offset and length fields of a record
    localparam int FIELD_BITS  = 24;
    localparam int PREFIX_BITS = 3;
    localparam int ZRUN_BITS   = 2;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

    localparam logic [OFFSET_BITS-1:0] POS_MAX   = {OFFSET_BITS{1'b1}};
    localparam logic [PREFIX_BITS-1:0] PFX_THREE = PREFIX_BITS'(3);
    localparam logic [PREFIX_BITS-1:0] PFX_FOUR  = PREFIX_BITS'(4);
    localparam logic [ZRUN_BITS-1:0]   ZRUN_MAX  = {ZRUN_BITS{1'b1}};
    localparam logic [7:0]             BYTE_ZERO = 8'h00;
    localparam logic [7:0]             BYTE_ONE  = 8'h01;

    typedef logic [OFFSET_BITS-1:0] t_pos;

    typedef struct packed {
        logic [FIELD_BITS-1:0]  offset;
        logic [FIELD_BITS-1:0]  length;
        logic [PREFIX_BITS-1:0] prefix;
        logic                   final_unit;
    } t_rec;

    // up to two records written into the result queue in one cycle
    typedef struct packed {
        logic v0;
        logic v1;
        t_rec rec0;
        t_rec rec1;
    } t_push;

    function automatic t_pos sat_inc(input t_pos v);
        t_pos r;
        r = (v == POS_MAX) ? v : v + t_pos'(1);
        return r;
    endfunction

    function automatic logic [FIELD_BITS-1:0] clip_field(input t_pos v);
        logic [FIELD_BITS+OFFSET_BITS-1:0] w;
        logic [FIELD_BITS+OFFSET_BITS-1:0] lim;
        w   = {{FIELD_BITS{1'b0}}, v};
        lim = {{OFFSET_BITS{1'b0}}, {FIELD_BITS{1'b1}}};
        if (w > lim) begin
            w = lim;
        end
        return w[FIELD_BITS-1:0];
    endfunction

    function automatic t_rec make_rec(input t_pos off, input t_pos fin_end,
                                      input logic [PREFIX_BITS-1:0] pfx,
                                      input logic fin);
        t_rec r;
        t_pos len;
        len          = (fin_end >= off) ? fin_end - off : t_pos'(0);
        r.offset     = clip_field(off);
        r.length     = clip_field(len);
        r.prefix     = pfx;
        r.final_unit = fin;
        return r;
    endfunction

endpackage

### rtl/core/asc_scan.sv
module asc_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_first_byte,
    input  logic                           i_last_byte,
    input  logic [asc_pkg::PREFIX_BITS-1:0] i_first_prefix,
    input  logic                           i_room,
    output asc_pkg::t_push                 o_push
);

    // input register
    logic                            r_v;
    logic [7:0]                      r_data;
    logic                            r_first;
    logic                            r_last;
    logic [asc_pkg::PREFIX_BITS-1:0] r_fpfx;

    // scan state
    asc_pkg::t_pos                   r_pos;
    asc_pkg::t_pos                   r_us;
    asc_pkg::t_pos                   r_bs;
    logic [asc_pkg::PREFIX_BITS-1:0] r_pfx;
    logic [asc_pkg::ZRUN_BITS-1:0]   r_zr;

    asc_pkg::t_pos                   pos0, us0, bs0, code_start;
    logic [asc_pkg::PREFIX_BITS-1:0] pfx0, np;
    logic [asc_pkg::ZRUN_BITS-1:0]   zr0;
    logic                            in_body, code, adv, accept;

    asc_pkg::t_pos                   n_pos, n_us, n_bs;
    logic [asc_pkg::PREFIX_BITS-1:0] n_pfx;
    logic [asc_pkg::ZRUN_BITS-1:0]   n_zr;
    asc_pkg::t_rec                   rec_code, rec_last;

    assign adv     = r_v && i_room;
    assign o_stall = r_v && !i_room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        // a first byte restarts the buffer
        pos0 = r_first ? '0 : r_pos;
        us0  = r_first ? '0 : r_us;
        pfx0 = r_first ? r_fpfx : r_pfx;
        bs0  = r_first ? asc_pkg::t_pos'(r_fpfx) : r_bs;
        zr0  = r_first ? '0 : r_zr;

        in_body    = pos0 >= bs0;
        code       = in_body && (r_data == asc_pkg::BYTE_ONE) && (zr0 >= 2'd2);
        np         = (zr0 == asc_pkg::ZRUN_MAX) ? asc_pkg::PFX_FOUR : asc_pkg::PFX_THREE;
        code_start = pos0 - asc_pkg::t_pos'(np - asc_pkg::PREFIX_BITS'(1));

        n_zr = zr0;
        if (in_body) begin
            if (r_data == asc_pkg::BYTE_ZERO) begin
                n_zr = (zr0 == asc_pkg::ZRUN_MAX) ? zr0 : zr0 + 2'd1;
            end else begin
                n_zr = '0;
            end
        end

        n_us  = code ? code_start : us0;
        n_pfx = code ? np : pfx0;
        n_bs  = code ? asc_pkg::sat_inc(pos0) : bs0;
        n_pos = asc_pkg::sat_inc(pos0);

        rec_code = asc_pkg::make_rec(us0, code_start, pfx0, 1'b0);
        rec_last = asc_pkg::make_rec(n_us, n_pos, n_pfx, 1'b1);

        o_push.v0   = adv && (code || r_last);
        o_push.v1   = adv && code && r_last;
        o_push.rec0 = code ? rec_code : rec_last;
        o_push.rec1 = rec_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_pos <= '0;
            r_us  <= '0;
            r_bs  <= '0;
            r_pfx <= '0;
            r_zr  <= '0;
        end else begin
            if (accept) begin
                r_v <= 1'b1;
            end else if (adv) begin
                r_v <= 1'b0;
            end
            if (adv) begin
                r_pos <= n_pos;
                r_us  <= n_us;
                r_bs  <= n_bs;
                r_pfx <= n_pfx;
                r_zr  <= n_zr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data  <= i_data_byte;
            r_first <= i_first_byte;
            r_last  <= i_last_byte;
            r_fpfx  <= i_first_prefix;
        end
    end

endmodule

### rtl/core/asc_queue.sv
module asc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  asc_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_stall,
    output asc_pkg::t_rec  o_rec
);

    asc_pkg::t_rec                 r_mem [asc_pkg::QDEPTH];
    logic [asc_pkg::QPTR_BITS-1:0] r_wp, r_rp;
    logic [asc_pkg::QCNT_BITS-1:0] r_cnt;
    logic                          pop;
    logic [asc_pkg::QPTR_BITS-1:0] wp1;

    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && !i_stall;
    // room for two records regardless of this cycle's pop
    assign o_room  = r_cnt <= asc_pkg::QCNT_BITS'(asc_pkg::QDEPTH - 2);
    assign o_rec   = r_mem[r_rp];
    assign wp1     = r_wp + asc_pkg::QPTR_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + asc_pkg::QPTR_BITS'(i_push.v0) + asc_pkg::QPTR_BITS'(i_push.v1);
            r_rp  <= r_rp + asc_pkg::QPTR_BITS'(pop);
            r_cnt <= r_cnt + asc_pkg::QCNT_BITS'(i_push.v0)
                     + asc_pkg::QCNT_BITS'(i_push.v1) - asc_pkg::QCNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.rec0;
        end
        if (i_push.v1) begin
            r_mem[wp1] <= i_push.rec1;
        end
    end

endmodule

### rtl/core/annexb_start_code_splitter_top.sv
// path: an accepted item waits in the input register until the result queue has room
//   for two; the scan then writes its records into the queue that feeds the outputs
// throughput: one item per cycle while the queue has room; results leave one per cycle
//   when not stalled; an item that closes a unit on the final byte gives two records
// reset: synchronous, active low; clears the scan state and empties the result queue
module annexb_start_code_splitter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // byte item channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_first_byte,
    input  logic                             i_last_byte,
    input  logic [asc_pkg::PREFIX_BITS-1:0]  i_first_prefix,
    // unit record channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [asc_pkg::FIELD_BITS-1:0]   o_unit_offset,
    output logic [asc_pkg::FIELD_BITS-1:0]   o_unit_length,
    output logic [asc_pkg::PREFIX_BITS-1:0]  o_prefix_length,
    output logic                             o_final_unit
);

    // records from the scanner, zero to two per item
    asc_pkg::t_push push;
    // queue can take two more records
    logic           room;
    asc_pkg::t_rec  rec;

    // input register plus start code scan; the scan state advances only when the
    // queue has room for both possible records of the registered item
    asc_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_last_byte    (i_last_byte),
        .i_first_prefix (i_first_prefix),
        .i_room         (room),
        .o_push         (push)
    );

    // small record queue separates the scanner from a stalled consumer
    asc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rec   (rec)
    );

    assign o_unit_offset   = rec.offset;
    assign o_unit_length   = rec.length;
    assign o_prefix_length = rec.prefix;
    assign o_final_unit    = rec.final_unit;

endmodule
